/* hw/rtl/mcc_pkg.sv */
// Shared types and constants of the cross center finder.
package mcc_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int LEN_WIDTH       = 31;
    localparam int QUEUE_DEPTH     = 2;
    localparam int NUM_PAIRINGS    = 3;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_ARM_FIRST  = 2'd0,
        REG_ARM_SECOND = 2'd1,
        REG_TOLERANCE  = 2'd2
    } cfg_index_t;

    typedef logic [1:0] marker_idx_t;

    // Configuration registers as seen by the back end
    typedef struct packed {
        logic [LEN_WIDTH-1:0] arm_first;
        logic [LEN_WIDTH-1:0] arm_second;
        logic [LEN_WIDTH-1:0] tolerance;
    } cfg_t;

    // Pairings tried in order: collinear partner of marker 0, then the other arm
    localparam marker_idx_t PAIR_C [NUM_PAIRINGS] = '{2'd1, 2'd2, 2'd3};
    localparam marker_idx_t PAIR_A [NUM_PAIRINGS] = '{2'd2, 2'd1, 2'd1};
    localparam marker_idx_t PAIR_B [NUM_PAIRINGS] = '{2'd3, 2'd3, 2'd2};

endpackage

/* hw/rtl/marker_cross_center_finder.sv */
// Top level of the marker cross center finder.
//
//  port group     dir  handshake               contents
//  input word     in   in_valid / in_ready     point0_x .. point3_z
//  result word    out  out_valid / out_ready   found, center_*, index fields
//  config write   in   cfg_write_en            cfg_index, cfg_data
//
// Words enter a 2-deep queue at one per cycle while it has room; the back end
// works them one at a time on a shared bit-serial multiplier (operand width
// B = max(COORD_WIDTH+1, 32)) and a restoring divider (COORD_WIDTH+2 quotient bits).
// Per word: 4 + 6n products for n pairings tried, plus 6 products and 3
// divisions when a center is computed.
// Reset clears the queue, sequencer and output valid; config resets to zero.
// A stalled result sits in the output register while the next word is worked.
module marker_cross_center_finder #(
    parameter int COORD_WIDTH = mcc_pkg::COORD_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [COORD_WIDTH-1:0]     point0_x,
    input  logic signed [COORD_WIDTH-1:0]     point0_y,
    input  logic signed [COORD_WIDTH-1:0]     point0_z,
    input  logic signed [COORD_WIDTH-1:0]     point1_x,
    input  logic signed [COORD_WIDTH-1:0]     point1_y,
    input  logic signed [COORD_WIDTH-1:0]     point1_z,
    input  logic signed [COORD_WIDTH-1:0]     point2_x,
    input  logic signed [COORD_WIDTH-1:0]     point2_y,
    input  logic signed [COORD_WIDTH-1:0]     point2_z,
    input  logic signed [COORD_WIDTH-1:0]     point3_x,
    input  logic signed [COORD_WIDTH-1:0]     point3_y,
    input  logic signed [COORD_WIDTH-1:0]     point3_z,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              found,
    output logic signed [COORD_WIDTH-1:0]     center_x,
    output logic signed [COORD_WIDTH-1:0]     center_y,
    output logic signed [COORD_WIDTH-1:0]     center_z,
    output logic [1:0]                        collinear_index,
    output logic [1:0]                        perpendicular_first_index,
    output logic [1:0]                        perpendicular_second_index,
    input  logic                              cfg_write_en,
    input  logic [1:0]                        cfg_index,
    input  logic [mcc_pkg::LEN_WIDTH-1:0]     cfg_data
);
    import mcc_pkg::*;

    localparam int ITEM_W = 3 * COORD_WIDTH + 18 * (COORD_WIDTH + 1);

    cfg_t                        cfg_reg, cfg_next;
    logic signed [COORD_WIDTH-1:0] point [4][3];
    logic signed [COORD_WIDTH-1:0] center [3];
    logic                        q_push, q_full, q_pop, q_valid;
    logic [ITEM_W-1:0]           q_wdata, q_rdata;

    // Configuration registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write_en)
        begin
            case (cfg_index)
                REG_ARM_FIRST:  cfg_next.arm_first  = cfg_data;
                REG_ARM_SECOND: cfg_next.arm_second = cfg_data;
                REG_TOLERANCE:  cfg_next.tolerance  = cfg_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign point[0] = '{point0_x, point0_y, point0_z};
    assign point[1] = '{point1_x, point1_y, point1_z};
    assign point[2] = '{point2_x, point2_y, point2_z};
    assign point[3] = '{point3_x, point3_y, point3_z};

    mcc_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .in_valid (in_valid),
        .in_ready (in_ready),
        .point    (point),
        .q_push   (q_push),
        .q_full   (q_full),
        .q_data   (q_wdata)
    );

    mcc_fifo #(
        .DATA_W (ITEM_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_data  (q_rdata)
    );

    mcc_back #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_back (
        .clk                        (clk),
        .rst_n                      (rst_n),
        .cfg                        (cfg_reg),
        .q_valid                    (q_valid),
        .q_data                     (q_rdata),
        .q_pop                      (q_pop),
        .out_valid                  (out_valid),
        .out_ready                  (out_ready),
        .found                      (found),
        .center                     (center),
        .collinear_index            (collinear_index),
        .perpendicular_first_index  (perpendicular_first_index),
        .perpendicular_second_index (perpendicular_second_index)
    );

    assign center_x = center[0];
    assign center_y = center[1];
    assign center_z = center[2];

endmodule

/* hw/rtl/mcc_front.sv */
// Front end: accepts marker words and forms the arm difference vectors.
module mcc_front #(
    parameter int COORD_WIDTH = mcc_pkg::COORD_WIDTH_DEF
) (
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [COORD_WIDTH-1:0]          point [4][3],
    output logic                                   q_push,
    input  logic                                   q_full,
    output logic [3*COORD_WIDTH+18*(COORD_WIDTH+1)-1:0] q_data
);
    import mcc_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int DW = W + 1;

    // Difference slots: P1-P0, P2-P0, P3-P0, P2-P3, P1-P3, P1-P2
    localparam int MINU [6] = '{1, 2, 3, 2, 1, 1};
    localparam int SUBT [6] = '{0, 0, 0, 3, 3, 2};

    logic signed [DW-1:0] diff [6][3];

    // Arm vectors, sign extended by one bit so they never wrap
    always_comb
    begin
        for (int s = 0; s < 6; s++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                diff[s][k] = {point[MINU[s]][k][W-1], point[MINU[s]][k]}
                           - {point[SUBT[s]][k][W-1], point[SUBT[s]][k]};
            end
        end
    end

    // Pack marker 0 and the six vectors into one queue word
    always_comb
    begin
        q_data = '0;
        for (int k = 0; k < 3; k++)
        begin
            q_data[k*W +: W] = point[0][k];
        end
        for (int s = 0; s < 6; s++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                q_data[3*W + (s*3+k)*DW +: DW] = diff[s][k];
            end
        end
    end

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

endmodule

/* hw/rtl/mcc_fifo.sv */
// Short queue between front and back end (depth a power of two).
module mcc_fifo #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = mcc_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              full,
    input  logic              pop,
    output logic              valid,
    output logic [DATA_W-1:0] pop_data
);
    import mcc_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              do_push, do_pop;

    assign full     = (count_reg == CW'(DEPTH));
    assign valid    = (count_reg != '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && valid;
    assign pop_data = mem[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = do_push ? AW'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? AW'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* hw/rtl/mcc_mul.sv */
// Shift-add multiplier, one multiplier bit per cycle.
module mcc_mul #(
    parameter int A_W = 34,
    parameter int B_W = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [A_W-1:0]     a,
    input  logic [B_W-1:0]     b,
    output logic               done,
    output logic [A_W+B_W-1:0] product
);
    import mcc_pkg::*;

    localparam int PW = A_W + B_W;
    localparam int CW = $clog2(B_W + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [PW-1:0] acc_reg, acc_next;
    logic [PW-1:0] mcand_reg, mcand_next;
    logic [B_W-1:0] mplier_reg, mplier_next;

    // One partial product per cycle
    always_comb
    begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        if (start)
        begin
            busy_next   = 1'b1;
            cnt_next    = CW'(B_W);
            acc_next    = '0;
            mcand_next  = PW'(a);
            mplier_next = b;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
            begin
                acc_next = acc_reg + mcand_reg;
            end
            mcand_next  = mcand_reg << 1;
            mplier_next = mplier_reg >> 1;
            cnt_next    = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

/* hw/rtl/mcc_back.sv */
// Back end: length tests, pairing search, projection and output register.
module mcc_back #(
    parameter int COORD_WIDTH = mcc_pkg::COORD_WIDTH_DEF
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  mcc_pkg::cfg_t                               cfg,
    input  logic                                        q_valid,
    input  logic [3*COORD_WIDTH+18*(COORD_WIDTH+1)-1:0] q_data,
    output logic                                        q_pop,
    output logic                                        out_valid,
    input  logic                                        out_ready,
    output logic                                        found,
    output logic signed [COORD_WIDTH-1:0]               center [3],
    output mcc_pkg::marker_idx_t                        collinear_index,
    output mcc_pkg::marker_idx_t                        perpendicular_first_index,
    output mcc_pkg::marker_idx_t                        perpendicular_second_index
);
    import mcc_pkg::*;

    localparam int W      = COORD_WIDTH;
    localparam int DW     = W + 1;
    localparam int SW     = 2 * W + 2;
    localparam int MA     = SW;
    localparam int MB     = (DW > 32) ? DW : 32;
    localparam int PW     = MA + MB;
    localparam int LSQ_W  = 2 * (LEN_WIDTH + 1);
    localparam int BW     = (SW > LSQ_W) ? SW : LSQ_W;
    localparam int DTW    = 2 * W + 3;
    localparam int QW     = W + 2;
    localparam int NW     = PW + 2;
    localparam int CNTW   = $clog2(QW + 1);
    localparam int ITEM_W = 3 * W + 18 * DW;

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_LSQ  = 9'b000000010,
        ST_SQ   = 9'b000000100,
        ST_TEST = 9'b000001000,
        ST_DOT  = 9'b000010000,
        ST_NUM  = 9'b000100000,
        ST_DIV  = 9'b001000000,
        ST_FIN  = 9'b010000000,
        ST_OUT  = 9'b100000000
    } back_state_t;

    back_state_t          state_reg, state_next;
    logic                 wait_reg, wait_next;
    logic [2:0]           op_idx_reg, op_idx_next;
    logic [1:0]           pair_reg, pair_next;
    logic [ITEM_W-1:0]    item_reg, item_next;
    logic [LSQ_W-1:0]     sqlen_reg [4];
    logic [LSQ_W-1:0]     sqlen_next [4];
    logic [SW-1:0]        s1_reg, s1_next, s2_reg, s2_next;
    logic signed [DTW-1:0] dot_reg, dot_next;
    logic [NW-1:0]        rem_reg, rem_next, dsh_reg, dsh_next;
    logic [QW-1:0]        quo_reg, quo_next;
    logic [CNTW-1:0]      cnt_reg, cnt_next;
    logic                 res_found_reg, res_found_next;
    logic signed [W-1:0]  res_center_reg [3];
    logic signed [W-1:0]  res_center_next [3];
    logic                 out_valid_reg, out_valid_next;
    logic                 found_reg;
    logic signed [W-1:0]  center_reg [3];
    logic [1:0]           collinear_reg, perp_first_reg, perp_second_reg;
    logic                 load_out;

    logic signed [W-1:0]  p0 [3];
    logic signed [DW-1:0] diff [6][3];
    logic                 mul_start, mul_done;
    logic [MA-1:0]        mul_a;
    logic [MB-1:0]        mul_b;
    logic [PW-1:0]        mul_p;

    function automatic logic [DW-1:0] mag_f(input logic signed [DW-1:0] v);
        return v[DW-1] ? DW'(~v + 1'b1) : v;
    endfunction

    function automatic logic len_ok_f(input logic tol_nz, input logic [BW-1:0] s,
                                      input logic [BW-1:0] hi, input logic [BW-1:0] lo,
                                      input logic below);
        return tol_nz && (s < hi) && (below || (lo < s));
    endfunction

    // Unpack the queued word
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            p0[k] = item_reg[k*W +: W];
        end
        for (int s = 0; s < 6; s++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                diff[s][k] = item_reg[3*W + (s*3+k)*DW +: DW];
            end
        end
    end

    // Operand selection for the current step
    logic [2:0]           sq_slot, a1_slot, dn_slot;
    logic [1:0]           sq_comp, k_idx;
    logic [LEN_WIDTH:0]   len_base, tol_ext, len_op;
    logic [DW-1:0]        a1_mag, dn_mag, sq_mag;
    logic                 a1_neg, dn_neg;
    logic [DTW-1:0]       dot_mag;

    always_comb
    begin
        k_idx    = op_idx_reg[1:0];
        a1_slot  = 3'(pair_reg);
        dn_slot  = 3'(PAIR_A[pair_reg] - 2'd1);
        sq_slot  = (op_idx_reg < 3'd3) ? a1_slot : 3'(3'd3 + 3'(pair_reg));
        sq_comp  = (op_idx_reg < 3'd3) ? op_idx_reg[1:0] : 2'(op_idx_reg - 3'd3);
        sq_mag   = mag_f(diff[sq_slot][sq_comp]);
        a1_mag   = mag_f(diff[a1_slot][k_idx]);
        a1_neg   = diff[a1_slot][k_idx][DW-1];
        dn_mag   = mag_f(diff[dn_slot][k_idx]);
        dn_neg   = diff[dn_slot][k_idx][DW-1];
        tol_ext  = {1'b0, cfg.tolerance};
        len_base = op_idx_reg[1] ? {1'b0, cfg.arm_second} : {1'b0, cfg.arm_first};
        len_op   = op_idx_reg[0] ? (len_base - tol_ext) : (len_base + tol_ext);
        dot_mag  = dot_reg[DTW-1] ? DTW'(~dot_reg + 1'b1) : dot_reg;

        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_LSQ:
            begin
                mul_a = MA'(len_op);
                mul_b = MB'(len_op);
            end
            ST_SQ:
            begin
                mul_a = MA'(sq_mag);
                mul_b = MB'(sq_mag);
            end
            ST_DOT:
            begin
                mul_a = MA'(a1_mag);
                mul_b = MB'(dn_mag);
            end
            ST_NUM:
            begin
                mul_a = MA'(dot_mag);
                mul_b = MB'(a1_mag);
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    // Length match of the current pairing, either arm order
    logic tol_nz, below_f, below_s, match;
    logic ok1f, ok1s, ok2f, ok2s;

    always_comb
    begin
        tol_nz  = (cfg.tolerance != '0);
        below_f = (cfg.arm_first  < cfg.tolerance);
        below_s = (cfg.arm_second < cfg.tolerance);
        ok1f = len_ok_f(tol_nz, BW'(s1_reg), BW'(sqlen_reg[0]), BW'(sqlen_reg[1]), below_f);
        ok1s = len_ok_f(tol_nz, BW'(s1_reg), BW'(sqlen_reg[2]), BW'(sqlen_reg[3]), below_s);
        ok2f = len_ok_f(tol_nz, BW'(s2_reg), BW'(sqlen_reg[0]), BW'(sqlen_reg[1]), below_f);
        ok2s = len_ok_f(tol_nz, BW'(s2_reg), BW'(sqlen_reg[2]), BW'(sqlen_reg[3]), below_s);
        match = (ok1f && ok2s) || (ok1s && ok2f);
    end

    // Rounded projection term added to marker 0, saturated
    logic                 negq;
    logic signed [W+2:0]  r_wide, q_ext, p0_ext, sat_max, sat_min;
    logic signed [W-1:0]  r_sat;

    always_comb
    begin
        negq    = dot_reg[DTW-1] ^ a1_neg;
        q_ext   = {1'b0, quo_reg};
        p0_ext  = {{3{p0[k_idx][W-1]}}, p0[k_idx]};
        sat_max = {4'b0000, {(W-1){1'b1}}};
        sat_min = {4'b1111, {(W-1){1'b0}}};
        r_wide  = negq ? (p0_ext - q_ext) : (p0_ext + q_ext);
        if (quo_reg[QW-1])
        begin
            r_sat = negq ? sat_min[W-1:0] : sat_max[W-1:0];
        end
        else if (r_wide > sat_max)
        begin
            r_sat = sat_max[W-1:0];
        end
        else if (r_wide < sat_min)
        begin
            r_sat = sat_min[W-1:0];
        end
        else
        begin
            r_sat = r_wide[W-1:0];
        end
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        wait_next      = wait_reg;
        op_idx_next    = op_idx_reg;
        pair_next      = pair_reg;
        item_next      = item_reg;
        sqlen_next     = sqlen_reg;
        s1_next        = s1_reg;
        s2_next        = s2_reg;
        dot_next       = dot_reg;
        rem_next       = rem_reg;
        dsh_next       = dsh_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        res_found_next = res_found_reg;
        res_center_next = res_center_reg;
        out_valid_next = out_valid_reg && !out_ready;
        load_out       = 1'b0;
        mul_start      = 1'b0;
        q_pop          = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop       = 1'b1;
                    item_next   = q_data;
                    op_idx_next = '0;
                    wait_next   = 1'b0;
                    state_next  = ST_LSQ;
                end
            end
            ST_LSQ:
            begin
                if (!wait_reg)
                begin
                    mul_start = 1'b1;
                    wait_next = 1'b1;
                end
                else if (mul_done)
                begin
                    wait_next = 1'b0;
                    sqlen_next[op_idx_reg[1:0]] = LSQ_W'(mul_p);
                    if (op_idx_reg == 3'd3)
                    begin
                        op_idx_next = '0;
                        pair_next   = '0;
                        s1_next     = '0;
                        s2_next     = '0;
                        state_next  = ST_SQ;
                    end
                    else
                    begin
                        op_idx_next = op_idx_reg + 3'd1;
                    end
                end
            end
            ST_SQ:
            begin
                if (!wait_reg)
                begin
                    mul_start = 1'b1;
                    wait_next = 1'b1;
                end
                else if (mul_done)
                begin
                    wait_next = 1'b0;
                    if (op_idx_reg < 3'd3)
                    begin
                        s1_next = s1_reg + SW'(mul_p);
                    end
                    else
                    begin
                        s2_next = s2_reg + SW'(mul_p);
                    end
                    if (op_idx_reg == 3'd5)
                    begin
                        state_next = ST_TEST;
                    end
                    else
                    begin
                        op_idx_next = op_idx_reg + 3'd1;
                    end
                end
            end
            ST_TEST:
            begin
                op_idx_next = '0;
                if (match && (s1_reg != '0))
                begin
                    dot_next   = '0;
                    state_next = ST_DOT;
                end
                else if (match || (pair_reg == 2'(NUM_PAIRINGS - 1)))
                begin
                    res_found_next = 1'b0;
                    for (int k = 0; k < 3; k++)
                    begin
                        res_center_next[k] = '0;
                    end
                    state_next = ST_OUT;
                end
                else
                begin
                    pair_next  = pair_reg + 2'd1;
                    s1_next    = '0;
                    s2_next    = '0;
                    state_next = ST_SQ;
                end
            end
            ST_DOT:
            begin
                if (!wait_reg)
                begin
                    mul_start = 1'b1;
                    wait_next = 1'b1;
                end
                else if (mul_done)
                begin
                    wait_next = 1'b0;
                    dot_next  = (a1_neg ^ dn_neg) ? (dot_reg - DTW'(mul_p))
                                                  : (dot_reg + DTW'(mul_p));
                    if (op_idx_reg == 3'd2)
                    begin
                        op_idx_next = '0;
                        state_next  = ST_NUM;
                    end
                    else
                    begin
                        op_idx_next = op_idx_reg + 3'd1;
                    end
                end
            end
            ST_NUM:
            begin
                if (!wait_reg)
                begin
                    mul_start = 1'b1;
                    wait_next = 1'b1;
                end
                else if (mul_done)
                begin
                    // numerator 2*|D_k|*|dot| + |D|^2 over 2*|D|^2, top quotient bit first
                    wait_next  = 1'b0;
                    rem_next   = NW'({mul_p, 1'b0}) + NW'(s1_reg);
                    dsh_next   = NW'(s1_reg) << QW;
                    quo_next   = '0;
                    cnt_next   = CNTW'(QW);
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (rem_reg >= dsh_reg)
                begin
                    rem_next = rem_reg - dsh_reg;
                end
                quo_next = {quo_reg[QW-2:0], (rem_reg >= dsh_reg)};
                dsh_next = dsh_reg >> 1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNTW'(1))
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                res_center_next[k_idx] = r_sat;
                if (op_idx_reg == 3'd2)
                begin
                    res_found_next = 1'b1;
                    state_next     = ST_OUT;
                end
                else
                begin
                    op_idx_next = op_idx_reg + 3'd1;
                    state_next  = ST_NUM;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wait_reg      <= 1'b0;
            op_idx_reg    <= '0;
            pair_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wait_reg      <= wait_next;
            op_idx_reg    <= op_idx_next;
            pair_reg      <= pair_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        item_reg       <= item_next;
        sqlen_reg      <= sqlen_next;
        s1_reg         <= s1_next;
        s2_reg         <= s2_next;
        dot_reg        <= dot_next;
        rem_reg        <= rem_next;
        dsh_reg        <= dsh_next;
        quo_reg        <= quo_next;
        res_found_reg  <= res_found_next;
        res_center_reg <= res_center_next;
        if (load_out)
        begin
            found_reg       <= res_found_reg;
            center_reg      <= res_center_reg;
            collinear_reg   <= res_found_reg ? PAIR_C[pair_reg] : 2'd0;
            perp_first_reg  <= res_found_reg ? PAIR_A[pair_reg] : 2'd0;
            perp_second_reg <= res_found_reg ? PAIR_B[pair_reg] : 2'd0;
        end
    end

    mcc_mul #(
        .A_W (MA),
        .B_W (MB)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    assign out_valid                  = out_valid_reg;
    assign found                      = found_reg;
    assign center                     = center_reg;
    assign collinear_index            = collinear_reg;
    assign perpendicular_first_index  = perp_first_reg;
    assign perpendicular_second_index = perp_second_reg;

    // Divisor is never zero: zero-length arms are turned away before division
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> dsh_reg != '0)
        else $error("division started with zero divisor");

    // A product only arrives when the sequencer is waiting for it
    a_mul_expected: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> wait_reg)
        else $error("unexpected multiplier result");

    // A found cross names three distinct markers other than marker 0
    a_found_idx: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && found_reg |-> collinear_reg != 2'd0 &&
        perp_first_reg != perp_second_reg && collinear_reg != perp_first_reg)
        else $error("bad marker indexes on found result");

    // A miss carries all-zero fields
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !found_reg |-> center_reg[0] == '0 && center_reg[1] == '0 &&
        center_reg[2] == '0 && collinear_reg == 2'd0 && perp_first_reg == 2'd0)
        else $error("nonzero fields on miss");

endmodule
